@@ rtl/core/bmt_pkg.sv @@
// Shared types and constants of the ball motion trigger.
package bmt_pkg;

    localparam int IN_COORD_W = 12;
    localparam int EXT_COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int PATH_W = 22;
    localparam int CAUSE_W = 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [PATH_W-1:0] PATH_MAX = 22'h3F_FFFF;
    localparam logic [PATH_W-1:0] MOVE_THR_RST = 22'd3200;

    // register byte-address bit that selects the register index
    localparam int REG_IDX_BIT = 2;
    localparam logic REG_IDX_THR = 1'b0;

    localparam logic [CAUSE_W-1:0] CAUSE_FEW = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NOBALL = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_APPEAR = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_DISAPPEAR = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_MOVED = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_BELOW = 3'd5;

    typedef struct packed {
        logic                  box_present;
        logic [IN_COORD_W-1:0] left_x;
        logic [IN_COORD_W-1:0] top_y;
        logic [IN_COORD_W-1:0] right_x;
        logic [IN_COORD_W-1:0] bottom_y;
        logic [SCORE_W-1:0]    score;
        logic                  is_ball;
        logic                  frame_end;
    } t_box;

    typedef struct packed {
        logic               significant;
        logic [CAUSE_W-1:0] cause;
        logic [PATH_W-1:0]  path_length;
    } t_res;

endpackage

@@ rtl/core/bmt_box_if.sv @@
// Valid/ready channel that carries detection box beats.
interface bmt_box_if;
    import bmt_pkg::*;

    logic valid;
    logic ready;
    t_box data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/bmt_res_if.sv @@
// Valid/ready channel that carries per-frame result beats.
interface bmt_res_if;
    import bmt_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/ball_motion_trigger.sv @@
// Ball motion trigger: per-frame best ball box, centroid window and path length check.
// A beat without frame_end gives no result. For a frame_end beat whose cause is decided
// by frame count or the last two frames, the result is registered and the done state
// moves it to the output register once that is free. A path walk reads one window slot
// at a time (read, then check); each segment takes two passes of one multiplier, one root
// bit per cycle and one accumulate before the next slot is read.
// Input ready only while idle. Sync active-low reset empties the window, threshold = 3200.
module ball_motion_trigger #(
    parameter int WINDOW_FRAMES = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bmt_box_if.sink                   i_box,
    bmt_res_if.source                 o_res,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bmt_pkg::APB_AW-1:0] paddr,
    input  logic [bmt_pkg::APB_DW-1:0] pwdata,
    output logic [bmt_pkg::APB_DW-1:0] prdata,
    output logic                      pready
);
    import bmt_pkg::*;

    // centroid is the plain corner sum: one extra bit per axis (half pixels)
    localparam int PW = COORD_BITS + 1;
    // dx*dx + dy*dy
    localparam int QW = 2 * PW + 1;
    // root width of (dx*dx + dy*dy) * 256
    localparam int RB = COORD_BITS + 6;
    localparam int RADW = 2 * RB;
    localparam int CNTW = $clog2(RB);
    localparam int SW = $clog2(WINDOW_FRAMES);
    localparam int FW = $clog2(WINDOW_FRAMES + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_SQX   = 9'b000001000,
        ST_SQY   = 9'b000010000,
        ST_ROOT  = 9'b000100000,
        ST_ACC   = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    t_state r_state;

    // per-frame best ball box
    logic [SCORE_W-1:0] r_best_score;
    logic [PW-1:0]      r_best_cx;
    logic [PW-1:0]      r_best_cy;
    logic               r_best_found;

    // centroid window: coordinates in a memory, valid bits in flops
    logic [2*PW-1:0]          r_mem [WINDOW_FRAMES];
    logic [2*PW-1:0]          r_mem_q;
    logic [WINDOW_FRAMES-1:0] r_pt_valid;
    logic                     r_q_valid;
    logic [SW-1:0]            r_slot;
    logic [FW-1:0]            r_frames;

    // path walk
    logic [SW-1:0]   r_addr;
    logic [SW-1:0]   r_k;
    logic            r_have_last;
    logic [PW-1:0]   r_last_cx;
    logic [PW-1:0]   r_last_cy;
    logic [PW-1:0]   r_dx;
    logic [PW-1:0]   r_dy;
    logic [QW-1:0]   r_sq;
    logic [RADW-1:0] r_rad;
    logic [RB+1:0]   r_rem;
    logic [RB-1:0]   r_root;
    logic [CNTW-1:0] r_cnt;
    logic [PATH_W-1:0] r_sum;

    logic [PATH_W-1:0] r_thr;
    t_res r_res;
    t_res r_out;
    logic r_out_valid;

    // input decode
    logic              accept;
    logic              upd;
    logic [PW-1:0]     cand_cx;
    logic [PW-1:0]     cand_cy;
    logic              n_found;
    logic [PW-1:0]     n_cx;
    logic [PW-1:0]     n_cy;
    logic [FW-1:0]     n_frames;
    logic [SW-1:0]     n_slot;
    logic [SW-1:0]     prev_slot;
    logic              p0;
    logic [COORD_BITS-1:0] lx, ty, rx, by;

    // walk datapath
    logic [PW-1:0]     q_cx;
    logic [PW-1:0]     q_cy;
    logic [PW-1:0]     dx_c;
    logic [PW-1:0]     dy_c;
    logic [PW-1:0]     mul_a;
    logic [2*PW-1:0]   prod;
    logic [RB+1:0]     rem_sh;
    logic [RB+1:0]     trial;
    logic              ge;
    logic [PATH_W:0]   sum_w;
    logic [PATH_W-1:0] n_sum;
    logic              walk_last;
    logic [SW-1:0]     n_addr;
    logic              out_free;
    logic              cfg_wr;

    assign lx = COORD_BITS'(EXT_COORD_W'(i_box.data.left_x));
    assign ty = COORD_BITS'(EXT_COORD_W'(i_box.data.top_y));
    assign rx = COORD_BITS'(EXT_COORD_W'(i_box.data.right_x));
    assign by = COORD_BITS'(EXT_COORD_W'(i_box.data.bottom_y));

    assign accept = i_box.valid && i_box.ready;
    assign i_box.ready = (r_state == ST_IDLE);

    // strictly greater than the best so far; a zero score never wins
    assign upd = i_box.data.box_present && i_box.data.is_ball &&
                 (i_box.data.score > r_best_score);
    assign cand_cx = PW'(lx) + PW'(rx);
    assign cand_cy = PW'(ty) + PW'(by);
    assign n_found = r_best_found || upd;
    assign n_cx = upd ? cand_cx : r_best_cx;
    assign n_cy = upd ? cand_cy : r_best_cy;

    assign n_frames = (r_frames == FW'(WINDOW_FRAMES)) ? r_frames : r_frames + FW'(1);
    assign n_slot = (r_slot == SW'(WINDOW_FRAMES - 1)) ? '0 : r_slot + SW'(1);
    assign prev_slot = (r_slot == '0) ? SW'(WINDOW_FRAMES - 1) : r_slot - SW'(1);
    assign p0 = r_pt_valid[prev_slot];

    assign q_cx = r_mem_q[2*PW-1:PW];
    assign q_cy = r_mem_q[PW-1:0];
    assign dx_c = (q_cx > r_last_cx) ? q_cx - r_last_cx : r_last_cx - q_cx;
    assign dy_c = (q_cy > r_last_cy) ? q_cy - r_last_cy : r_last_cy - q_cy;

    // one multiplier, squaring dx then dy
    assign mul_a = (r_state == ST_SQX) ? r_dx : r_dy;
    assign prod = (2*PW)'(mul_a) * (2*PW)'(mul_a);

    // one root bit per cycle: bring down two radicand bits, try root*4+1
    assign rem_sh = {r_rem[RB-1:0], r_rad[RADW-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign ge = (rem_sh >= trial);

    assign sum_w = (PATH_W+1)'(r_sum) + (PATH_W+1)'(r_root);
    assign n_sum = (sum_w > (PATH_W+1)'(PATH_MAX)) ? PATH_MAX : sum_w[PATH_W-1:0];

    assign walk_last = (r_k == SW'(WINDOW_FRAMES - 1));
    assign n_addr = (r_addr == SW'(WINDOW_FRAMES - 1)) ? '0 : r_addr + SW'(1);
    assign out_free = !r_out_valid || o_res.ready;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[REG_IDX_BIT] == REG_IDX_THR) ? APB_DW'(r_thr) : '0;

    assign o_res.valid = r_out_valid;
    assign o_res.data = r_out;

    // window memory: write at frame close, read during the walk
    always_ff @(posedge i_clk) begin
        if (accept && i_box.data.frame_end) begin
            r_mem[r_slot] <= {n_cx, n_cy};
        end
        if (r_state == ST_READ) begin
            r_mem_q <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_best_score <= '0;
            r_best_found <= 1'b0;
            r_pt_valid <= '0;
            r_slot <= '0;
            r_frames <= '0;
            r_out_valid <= 1'b0;
            r_thr <= MOVE_THR_RST;
        end else begin
            if (cfg_wr && paddr[REG_IDX_BIT] == REG_IDX_THR) begin
                r_thr <= pwdata[PATH_W-1:0];
            end
            // the done state reloads the output register itself
            if (r_out_valid && o_res.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (!i_box.data.frame_end) begin
                            // fold this box into the frame's best
                            r_best_score <= upd ? i_box.data.score : r_best_score;
                            r_best_cx <= n_cx;
                            r_best_cy <= n_cy;
                            r_best_found <= n_found;
                        end else begin
                            // close the frame: store centroid, drop the best box
                            r_pt_valid[r_slot] <= n_found;
                            r_slot <= n_slot;
                            r_frames <= n_frames;
                            r_best_score <= '0;
                            r_best_found <= 1'b0;
                            r_res.path_length <= '0;
                            if (n_frames < FW'(2)) begin
                                r_res.significant <= 1'b0;
                                r_res.cause <= CAUSE_FEW;
                                r_state <= ST_DONE;
                            end else if (!n_found && !p0) begin
                                r_res.significant <= 1'b0;
                                r_res.cause <= CAUSE_NOBALL;
                                r_state <= ST_DONE;
                            end else if (n_found && !p0) begin
                                r_res.significant <= 1'b1;
                                r_res.cause <= CAUSE_APPEAR;
                                r_state <= ST_DONE;
                            end else if (!n_found && p0) begin
                                r_res.significant <= 1'b1;
                                r_res.cause <= CAUSE_DISAPPEAR;
                                r_state <= ST_DONE;
                            end else begin
                                // walk the window from the oldest slot
                                r_addr <= n_slot;
                                r_k <= '0;
                                r_have_last <= 1'b0;
                                r_sum <= '0;
                                r_state <= ST_READ;
                            end
                        end
                    end
                end
                ST_READ: begin
                    r_q_valid <= r_pt_valid[r_addr];
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (r_q_valid) begin
                        r_last_cx <= q_cx;
                        r_last_cy <= q_cy;
                        r_have_last <= 1'b1;
                    end
                    if (r_q_valid && r_have_last) begin
                        r_dx <= dx_c;
                        r_dy <= dy_c;
                        r_state <= ST_SQX;
                    end else if (walk_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_k <= r_k + SW'(1);
                        r_addr <= n_addr;
                        r_state <= ST_READ;
                    end
                end
                ST_SQX: begin
                    r_sq <= QW'(prod);
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_rad <= RADW'(r_sq + QW'(prod)) << 8;
                    r_rem <= '0;
                    r_root <= '0;
                    r_cnt <= CNTW'(RB - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_rem <= ge ? rem_sh - trial : rem_sh;
                    r_root <= {r_root[RB-2:0], ge};
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    // saturate the running path length
                    r_sum <= n_sum;
                    if (walk_last) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_k <= r_k + SW'(1);
                        r_addr <= n_addr;
                        r_state <= ST_READ;
                    end
                end
                ST_FIN: begin
                    r_res.path_length <= r_sum;
                    r_res.significant <= (r_sum >= r_thr);
                    r_res.cause <= (r_sum >= r_thr) ? CAUSE_MOVED : CAUSE_BELOW;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_out <= r_res;
                        r_out_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_sig_matches_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.significant == (r_out.cause == CAUSE_APPEAR ||
            r_out.cause == CAUSE_DISAPPEAR || r_out.cause == CAUSE_MOVED)))
        else $error("significant flag disagrees with cause");

    a_path_zero_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.cause != CAUSE_MOVED && r_out.cause != CAUSE_BELOW)
        |-> (r_out.path_length == '0))
        else $error("path length set for a cause without a walk");

    a_frame_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_box.data.frame_end) |=> (r_state != ST_IDLE))
        else $error("frame end accepted without producing a result");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= FW'(WINDOW_FRAMES))
        else $error("frame count beyond window depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result changed before it was taken");

endmodule
